>>> src/thwl_pkg.sv
// Shared types, constants and helpers of the two-wire handshake link.
package thwl_pkg;

  localparam int BUFFER_DEPTH = 512;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = 9;
  localparam int BIT_CNT_W    = 4;
  localparam int BYTE_W       = 8;
  localparam int OP_W         = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [OP_W-1:0] {
    OP_LINE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_code_t;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_LINE,
    REQ_PUSH,
    REQ_POP
  } req_kind_t;

  typedef enum logic [1:0] {
    PH_FLOAT = 2'd0,
    PH_RING  = 2'd1,
    PH_TIP   = 2'd2
  } phase_t;

  typedef struct packed {
    req_kind_t kind;
    logic      tip_level;
    logic      ring_level;
    byte_t     byte_in;
  } req_t;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = BIT_CNT_W'(BYTE_W);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT      = BIT_CNT_W'(BYTE_W - 1);

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t res;
    if (p == PTR_W'(BUFFER_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + PTR_W'(1);
    end
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] fill_count(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] sum;
    sum = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      sum = sum + (PTR_W+1)'(BUFFER_DEPTH);
    end
    return CNT_W'(sum);
  endfunction

endpackage

>>> src/two_wire_handshake_link.sv
// Top level of the two-wire handshake link with its byte ring buffer.
// A request passes from the two-entry front queue to the result register; one that needs
// a byte from the buffer (a pop, or a send step that loads a new byte) first waits for the
// single registered read port. Throughput: one request per cycle while results are taken
// and no buffer read is awaited. Reset (rst_n low, synchronous) empties the buffer, clears
// the transmitter, idles the line phase and selects receive mode; no clearing pass.
module two_wire_handshake_link (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_tip_level,
  input  logic       in_ring_level,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tip_pull_low,
  output logic       out_ring_pull_low,
  output logic [7:0] out_byte_out,
  output logic       out_byte_valid,
  output logic       out_push_accepted,
  output logic       out_sending_active,
  output logic       out_link_error,
  output logic [8:0] out_buffer_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_link_mode
);

  logic           q_valid;
  thwl_pkg::req_t q_req;
  logic           q_pop;

  thwl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_tip_level  (in_tip_level),
    .in_ring_level (in_ring_level),
    .in_byte_in    (in_byte_in),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  thwl_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_req              (q_req),
    .q_pop              (q_pop),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_link_mode      (cfg_link_mode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tip_pull_low   (out_tip_pull_low),
    .out_ring_pull_low  (out_ring_pull_low),
    .out_byte_out       (out_byte_out),
    .out_byte_valid     (out_byte_valid),
    .out_push_accepted  (out_push_accepted),
    .out_sending_active (out_sending_active),
    .out_link_error     (out_link_error),
    .out_buffer_count   (out_buffer_count)
  );

endmodule

>>> src/thwl_front.sv
// Front end: accepts requests, decodes the operation and queues them.
module thwl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic              in_tip_level,
  input  logic              in_ring_level,
  input  logic [7:0]        in_byte_in,
  output logic              q_valid,
  output thwl_pkg::req_t    q_req,
  input  logic              q_pop
);

  thwl_pkg::req_t q_r [2];
  logic           wr_sel_r, wr_sel_nxt;
  logic           rd_sel_r, rd_sel_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           pop;
  thwl_pkg::req_t decoded;

  always_comb begin
    decoded.tip_level  = in_tip_level;
    decoded.ring_level = in_ring_level;
    decoded.byte_in    = in_byte_in;
    case (in_operation)
      thwl_pkg::OP_LINE: decoded.kind = thwl_pkg::REQ_LINE;
      thwl_pkg::OP_PUSH: decoded.kind = thwl_pkg::REQ_PUSH;
      thwl_pkg::OP_POP:  decoded.kind = thwl_pkg::REQ_POP;
      default:           decoded.kind = thwl_pkg::REQ_NONE;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_req    = q_r[rd_sel_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_sel_nxt = push ? ~wr_sel_r : wr_sel_r;
    rd_sel_nxt = pop ? ~rd_sel_r : rd_sel_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_sel_r] <= decoded;
    end
  end

endmodule

>>> src/thwl_back.sv
// Back end: line protocol, byte ring buffer and result register.
module thwl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  thwl_pkg::req_t    q_req,
  output logic              q_pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_link_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_tip_pull_low,
  output logic              out_ring_pull_low,
  output logic [7:0]        out_byte_out,
  output logic              out_byte_valid,
  output logic              out_push_accepted,
  output logic              out_sending_active,
  output logic              out_link_error,
  output logic [8:0]        out_buffer_count
);

  thwl_pkg::byte_t mem [thwl_pkg::BUFFER_DEPTH];
  thwl_pkg::byte_t mem_q_r;

  thwl_pkg::ptr_t                    rp_r, rp_nxt;
  thwl_pkg::ptr_t                    wp_r, wp_nxt;
  logic [thwl_pkg::BIT_CNT_W-1:0]    bc_r, bc_nxt;
  thwl_pkg::byte_t                   sr_r, sr_nxt;
  thwl_pkg::phase_t                  ph_r, ph_nxt;
  logic                              txen_r, txen_nxt;
  logic                              mode_r;
  logic                              rd_done_r, rd_done_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic                              tip_low_r, ring_low_r;
  thwl_pkg::byte_t                   byte_out_r;
  logic                              byte_valid_r, push_acc_r, sending_r, error_r;
  logic [thwl_pkg::CNT_W-1:0]        count_r;

  logic                              wr_en;
  thwl_pkg::ptr_t                    wr_addr;
  thwl_pkg::byte_t                   wr_data;
  logic                              err;
  thwl_pkg::byte_t                   got;
  logic                              valid_pop;
  logic                              accepted;
  logic                              do_send;
  logic                              fwd;
  logic                              uses_mem;
  logic                              bit_val;
  thwl_pkg::byte_t                   load_byte;
  logic                              out_free;
  logic                              fire;
  logic                              cfg_fire;
  logic                              sending;
  logic                              tip_low, ring_low;

  assign sending   = mode_r;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    bc_nxt    = bc_r;
    sr_nxt    = sr_r;
    ph_nxt    = ph_r;
    txen_nxt  = txen_r;
    wr_en     = 1'b0;
    wr_addr   = wp_r;
    wr_data   = q_req.byte_in;
    err       = 1'b0;
    got       = '0;
    valid_pop = 1'b0;
    accepted  = 1'b0;
    do_send   = 1'b0;
    fwd       = 1'b0;
    uses_mem  = 1'b0;
    bit_val   = 1'b0;
    load_byte = mem_q_r;

    case (q_req.kind)
      thwl_pkg::REQ_LINE: begin
        if (sending) begin
          do_send = txen_r;
        end else begin
          if (ph_r == thwl_pkg::PH_FLOAT && !q_req.tip_level) begin
            ph_nxt  = thwl_pkg::PH_TIP;
            bit_val = 1'b0;
          end else if (ph_r == thwl_pkg::PH_FLOAT && !q_req.ring_level) begin
            ph_nxt  = thwl_pkg::PH_RING;
            bit_val = 1'b1;
          end else if (ph_r == thwl_pkg::PH_TIP && q_req.tip_level) begin
            ph_nxt = thwl_pkg::PH_FLOAT;
          end else if (ph_r == thwl_pkg::PH_RING && q_req.ring_level) begin
            ph_nxt = thwl_pkg::PH_FLOAT;
          end else begin
            err = 1'b1;
          end
          // shift in a bit on a new line pull
          if (ph_r == thwl_pkg::PH_FLOAT && !err) begin
            sr_nxt = {bit_val, sr_r[thwl_pkg::BYTE_W-1:1]};
            bc_nxt = bc_r + thwl_pkg::BIT_CNT_W'(1);
            if (bc_nxt == thwl_pkg::BITS_PER_BYTE) begin
              wr_en   = 1'b1;
              wr_addr = wp_r;
              wr_data = sr_nxt;
              wp_nxt  = thwl_pkg::ptr_inc(wp_r);
              bc_nxt  = '0;
              if (wp_nxt == rp_r) begin
                err = 1'b1;
              end
            end
          end
        end
      end
      thwl_pkg::REQ_PUSH: begin
        if (sending && thwl_pkg::ptr_inc(wp_r) != rp_r) begin
          wr_en    = 1'b1;
          wr_addr  = wp_r;
          wr_data  = q_req.byte_in;
          wp_nxt   = thwl_pkg::ptr_inc(wp_r);
          accepted = 1'b1;
          fwd      = (rp_r == wp_r);
          if (!txen_r) begin
            txen_nxt = 1'b1;
            do_send  = 1'b1;
          end
        end
      end
      thwl_pkg::REQ_POP: begin
        if (!sending && rp_r != wp_r) begin
          got       = mem_q_r;
          uses_mem  = 1'b1;
          rp_nxt    = thwl_pkg::ptr_inc(rp_r);
          valid_pop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_send) begin
      if (ph_r == thwl_pkg::PH_FLOAT) begin
        if (rp_nxt == wp_nxt && bc_r == '0) begin
          txen_nxt = 1'b0;
        end else if (!q_req.tip_level || !q_req.ring_level) begin
          err = 1'b1;
        end else begin
          if (bc_r == '0) begin
            load_byte = fwd ? q_req.byte_in : mem_q_r;
            uses_mem  = !fwd;
            rp_nxt    = thwl_pkg::ptr_inc(rp_nxt);
            bit_val   = load_byte[0];
            sr_nxt    = load_byte >> 1;
            bc_nxt    = thwl_pkg::LAST_BIT;
          end else begin
            bit_val = sr_r[0];
            sr_nxt  = sr_r >> 1;
            bc_nxt  = bc_r - thwl_pkg::BIT_CNT_W'(1);
          end
          ph_nxt = bit_val ? thwl_pkg::PH_RING : thwl_pkg::PH_TIP;
        end
      end else if (ph_r == thwl_pkg::PH_TIP && !q_req.ring_level) begin
        ph_nxt = thwl_pkg::PH_FLOAT;
      end else if (ph_r == thwl_pkg::PH_RING && !q_req.tip_level) begin
        ph_nxt = thwl_pkg::PH_FLOAT;
      end else begin
        err = 1'b1;
      end
    end

    if (err) begin
      rp_nxt   = '0;
      wp_nxt   = '0;
      bc_nxt   = '0;
      sr_nxt   = '0;
      ph_nxt   = thwl_pkg::PH_FLOAT;
      txen_nxt = 1'b0;
    end

    if (sending) begin
      tip_low  = (ph_nxt == thwl_pkg::PH_TIP);
      ring_low = (ph_nxt == thwl_pkg::PH_RING);
    end else begin
      ring_low = (ph_nxt == thwl_pkg::PH_TIP);
      tip_low  = (ph_nxt == thwl_pkg::PH_RING);
    end
  end

  // hold a request that reads the buffer until the registered buffer read completes
  assign out_free = !out_valid_r || out_ready;
  assign fire     = q_valid && out_free && !(uses_mem && !rd_done_r);
  assign q_pop    = fire;

  always_comb begin
    rd_done_nxt = rd_done_r;
    if (fire || cfg_fire) begin
      rd_done_nxt = 1'b0;
    end else if (q_valid && out_free && uses_mem) begin
      rd_done_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      bc_r        <= '0;
      sr_r        <= '0;
      ph_r        <= thwl_pkg::PH_FLOAT;
      txen_r      <= 1'b0;
      mode_r      <= 1'b0;
      rd_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_done_r   <= rd_done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        mode_r <= cfg_link_mode;
        rp_r   <= '0;
        wp_r   <= '0;
        bc_r   <= '0;
        sr_r   <= '0;
        ph_r   <= thwl_pkg::PH_FLOAT;
        txen_r <= 1'b0;
      end else if (fire) begin
        rp_r   <= rp_nxt;
        wp_r   <= wp_nxt;
        bc_r   <= bc_nxt;
        sr_r   <= sr_nxt;
        ph_r   <= ph_nxt;
        txen_r <= txen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tip_low_r    <= tip_low;
      ring_low_r   <= ring_low;
      byte_out_r   <= got;
      byte_valid_r <= valid_pop;
      push_acc_r   <= accepted;
      sending_r    <= sending && txen_nxt;
      error_r      <= err;
      count_r      <= thwl_pkg::fill_count(wp_nxt, rp_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tip_pull_low   = tip_low_r;
  assign out_ring_pull_low  = ring_low_r;
  assign out_byte_out       = byte_out_r;
  assign out_byte_valid     = byte_valid_r;
  assign out_push_accepted  = push_acc_r;
  assign out_sending_active = sending_r;
  assign out_link_error     = error_r;
  assign out_buffer_count   = count_r;

`ifndef ASSERT_OFF
  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= thwl_pkg::BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  a_read_wait_once: assert property (@(posedge clk) disable iff (!rst_n)
    rd_done_r |=> !rd_done_r)
    else $error("buffer read wait longer than one cycle");

  a_rx_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    !mode_r |-> !txen_r)
    else $error("transmitter enabled in receive mode");

  a_error_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && error_r) |-> (count_r == '0 && !tip_low_r && !ring_low_r))
    else $error("error result with buffer or lines still held");
`endif

endmodule

>>> dv/two_wire_handshake_link_checker.sv
// Link status predictor and result checker for the two-wire handshake link.
module two_wire_handshake_link_checker
  import thwl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_tip_level,
  input  logic       in_ring_level,
  input  logic [7:0] in_byte_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_tip_pull_low,
  input  logic       out_ring_pull_low,
  input  logic [7:0] out_byte_out,
  input  logic       out_byte_valid,
  input  logic       out_push_accepted,
  input  logic       out_sending_active,
  input  logic       out_link_error,
  input  logic [8:0] out_buffer_count,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_link_mode,
  output int         outstanding,
  output int         mismatches
);

  typedef struct packed {
    logic             tip_low;
    logic             ring_low;
    byte_t            data;
    logic             data_ok;
    logic             stored;
    logic             busy;
    logic             err;
    logic [CNT_W-1:0] fill;
  } link_status_t;

  byte_t                fifo_mem [BUFFER_DEPTH];
  ptr_t                 rd_ptr;
  ptr_t                 wr_ptr;
  logic [BIT_CNT_W-1:0] bit_cnt;
  byte_t                shreg;
  phase_t               phase;
  logic                 tx_on;
  logic                 send_mode;
  logic                 err_flag;
  link_status_t         expected_status [$];

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic ptr_t next_ptr(input ptr_t p);
    return (p == ptr_t'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void drop_link();
    rd_ptr  = '0;
    wr_ptr  = '0;
    bit_cnt = '0;
    shreg   = '0;
    phase   = PH_FLOAT;
    tx_on   = 1'b0;
  endfunction

  function automatic void flag_error();
    drop_link();
    err_flag = 1'b1;
  endfunction

  function automatic void shift_in_bit(input logic b);
    shreg   = {b, shreg[BYTE_W-1:1]};
    bit_cnt = bit_cnt + 1'b1;
    if (bit_cnt == BITS_PER_BYTE) begin
      fifo_mem[wr_ptr] = shreg;
      wr_ptr           = next_ptr(wr_ptr);
      bit_cnt          = '0;
      if (wr_ptr == rd_ptr) begin
        flag_error();
      end
    end
  endfunction

  function automatic logic shift_out_bit();
    logic b;
    if (bit_cnt == '0) begin
      shreg   = fifo_mem[rd_ptr];
      rd_ptr  = next_ptr(rd_ptr);
      bit_cnt = BITS_PER_BYTE;
    end
    bit_cnt = bit_cnt - 1'b1;
    b       = shreg[0];
    shreg   = shreg >> 1;
    return b;
  endfunction

  function automatic void line_send(input logic tip, input logic ring);
    if (phase == PH_FLOAT) begin
      if (rd_ptr == wr_ptr && bit_cnt == '0) begin
        tx_on = 1'b0;
      end else if (!(tip && ring)) begin
        flag_error();
      end else begin
        phase = shift_out_bit() ? PH_RING : PH_TIP;
      end
    end else if (phase == PH_TIP && !ring) begin
      phase = PH_FLOAT;
    end else if (phase == PH_RING && !tip) begin
      phase = PH_FLOAT;
    end else begin
      flag_error();
    end
  endfunction

  function automatic void line_receive(input logic tip, input logic ring);
    if (phase == PH_FLOAT && !tip) begin
      phase = PH_TIP;
      shift_in_bit(1'b0);
    end else if (phase == PH_FLOAT && !ring) begin
      phase = PH_RING;
      shift_in_bit(1'b1);
    end else if (phase == PH_TIP && tip) begin
      phase = PH_FLOAT;
    end else if (phase == PH_RING && ring) begin
      phase = PH_FLOAT;
    end else begin
      flag_error();
    end
  endfunction

  function automatic link_status_t predict_status(input logic [1:0] op, input logic tip,
                                                  input logic ring, input byte_t data);
    link_status_t s;
    s        = '0;
    err_flag = 1'b0;
    case (op)
      OP_LINE: begin
        if (send_mode) begin
          if (tx_on) begin
            line_send(tip, ring);
          end
        end else begin
          line_receive(tip, ring);
        end
      end
      OP_PUSH: begin
        if (send_mode && next_ptr(wr_ptr) != rd_ptr) begin
          fifo_mem[wr_ptr] = data;
          wr_ptr           = next_ptr(wr_ptr);
          s.stored         = 1'b1;
          if (!tx_on) begin
            tx_on = 1'b1;
            line_send(tip, ring);
          end
        end
      end
      OP_POP: begin
        if (!send_mode && rd_ptr != wr_ptr) begin
          s.data    = fifo_mem[rd_ptr];
          rd_ptr    = next_ptr(rd_ptr);
          s.data_ok = 1'b1;
        end
      end
      default: ;
    endcase
    if (send_mode) begin
      s.tip_low  = (phase == PH_TIP);
      s.ring_low = (phase == PH_RING);
    end else begin
      s.ring_low = (phase == PH_TIP);
      s.tip_low  = (phase == PH_RING);
    end
    s.busy = send_mode && tx_on;
    s.err  = err_flag;
    s.fill = CNT_W'((int'(wr_ptr) + BUFFER_DEPTH - int'(rd_ptr)) % BUFFER_DEPTH);
    return s;
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t mismatch %s: expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    link_status_t got;
    link_status_t want;
    if (!rst_n) begin
      send_mode = 1'b0;
      drop_link();
      expected_status.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{tip_low: out_tip_pull_low, ring_low: out_ring_pull_low, data: out_byte_out,
                data_ok: out_byte_valid, stored: out_push_accepted, busy: out_sending_active,
                err: out_link_error, fill: out_buffer_count};
        if (expected_status.size() == 0) begin
          $display("%0t unexpected result: expected none actual 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("tip_pull_low", want.tip_low, got.tip_low);
          check_field("ring_pull_low", want.ring_low, got.ring_low);
          check_field("byte_out", want.data, got.data);
          check_field("byte_valid", want.data_ok, got.data_ok);
          check_field("push_accepted", want.stored, got.stored);
          check_field("sending_active", want.busy, got.busy);
          check_field("link_error", want.err, got.err);
          check_field("buffer_count", want.fill, got.fill);
        end
      end
      if (cfg_valid && cfg_ready) begin
        send_mode = cfg_link_mode;
        drop_link();
      end
      if (in_valid && in_ready) begin
        expected_status.push_back(predict_status(in_operation, in_tip_level, in_ring_level,
                                                 in_byte_in));
      end
      outstanding <= expected_status.size();
    end
  end

endmodule

>>> dv/two_wire_handshake_link_tb.sv
// Top of the two-wire handshake link testbench: clock, reset, requests and verdict.
module two_wire_handshake_link_tb;
  import thwl_pkg::*;

  localparam int         CYCLE_LIMIT  = 500000;
  localparam logic [1:0] OP_UNDEF     = 2'd3;
  localparam logic       MODE_RECEIVE = 1'b0;
  localparam logic       MODE_SEND    = 1'b1;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation  = OP_LINE;
  logic       in_tip_level  = 1'b1;
  logic       in_ring_level = 1'b1;
  logic [7:0] in_byte_in    = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic       out_tip_pull_low;
  logic       out_ring_pull_low;
  logic [7:0] out_byte_out;
  logic       out_byte_valid;
  logic       out_push_accepted;
  logic       out_sending_active;
  logic       out_link_error;
  logic [8:0] out_buffer_count;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic       cfg_link_mode = 1'b0;
  int         outstanding;
  int         mismatches;

  int     send_idle_pct = 27;
  int     recv_idle_pct = 86;
  int     cycle_count   = 0;
  logic   sender_on;
  logic   sender_busy;
  int     sender_bits;
  phase_t rx_wire;
  int     rx_bits;
  int     rx_bytes;

  two_wire_handshake_link i_dut (.*);

  two_wire_handshake_link_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic byte_t rnd_byte();
    return byte_t'($urandom_range(255));
  endfunction

  function automatic void tx_clear();
    sender_on   = 1'b0;
    sender_busy = 1'b0;
    sender_bits = 0;
  endfunction

  function automatic void rx_clear();
    rx_wire  = PH_FLOAT;
    rx_bits  = 0;
    rx_bytes = 0;
  endfunction

  task automatic issue(input logic [1:0] op, input logic tip, input logic ring,
                       input byte_t data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_tip_level  <= tip;
    in_ring_level <= ring;
    in_byte_in    <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    cfg_valid     <= 1'b1;
    cfg_link_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tx_clear();
    rx_clear();
  endtask

  // Act as a well-behaved sender on the far end of the line.
  task automatic rx_line();
    case (rx_wire)
      PH_TIP: begin
        issue(OP_LINE, 1'b1, coin(), rnd_byte());
        rx_wire = PH_FLOAT;
      end
      PH_RING: begin
        issue(OP_LINE, coin(), 1'b1, rnd_byte());
        rx_wire = PH_FLOAT;
      end
      default: begin
        if (coin()) begin
          issue(OP_LINE, 1'b1, 1'b0, rnd_byte());
          rx_wire = PH_RING;
        end else begin
          issue(OP_LINE, 1'b0, coin(), rnd_byte());
          rx_wire = PH_TIP;
        end
        rx_bits++;
        if (rx_bits == BYTE_W) begin
          rx_bits = 0;
          rx_bytes++;
          if (rx_bytes == BUFFER_DEPTH) begin
            rx_clear();
          end
        end
      end
    endcase
  endtask

  task automatic rx_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      issue(OP_POP, coin(), coin(), rnd_byte());
      if (rx_bytes > 0) begin
        rx_bytes--;
      end
    end else if (pick < 19) begin
      issue(pick < 17 ? OP_PUSH : OP_UNDEF, coin(), coin(), rnd_byte());
    end else if (pick < 23) begin
      case (rx_wire)
        PH_TIP:  issue(OP_LINE, 1'b0, coin(), rnd_byte());
        PH_RING: issue(OP_LINE, coin(), 1'b0, rnd_byte());
        default: issue(OP_LINE, 1'b1, 1'b1, rnd_byte());
      endcase
      rx_clear();
    end else begin
      rx_line();
    end
  endtask

  task automatic tx_step();
    int         pick;
    logic [1:0] bad;
    pick = $urandom_range(99);
    bad  = 2'($urandom_range(2));
    if (pick < 10) begin
      issue(pick < 6 ? OP_POP : OP_UNDEF, coin(), coin(), rnd_byte());
    end else if (pick < 15) begin
      if (!sender_on) begin
        issue(OP_PUSH, bad[1], bad[0], rnd_byte());
        tx_clear();
      end else if (sender_busy) begin
        issue(OP_LINE, 1'b1, 1'b1, rnd_byte());
        tx_clear();
      end else if (sender_bits > 0) begin
        issue(OP_LINE, bad[1], bad[0], rnd_byte());
        tx_clear();
      end else begin
        issue(OP_LINE, coin(), coin(), rnd_byte());
        sender_on = 1'b0;
      end
    end else if (!sender_on || (pick < 35 && sender_bits < 24)) begin
      if (sender_on) begin
        issue(OP_PUSH, coin(), coin(), rnd_byte());
      end else begin
        issue(OP_PUSH, 1'b1, 1'b1, rnd_byte());
      end
      sender_bits += BYTE_W;
      if (!sender_on) begin
        sender_on   = 1'b1;
        sender_busy = 1'b1;
        sender_bits--;
      end
    end else if (sender_busy) begin
      issue(OP_LINE, 1'b0, 1'b0, rnd_byte());
      sender_busy = 1'b0;
    end else begin
      issue(OP_LINE, 1'b1, 1'b1, rnd_byte());
      if (sender_bits == 0) begin
        sender_on = 1'b0;
      end else begin
        sender_bits--;
        sender_busy = 1'b1;
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    tx_clear();
    rx_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    issue(OP_POP, 1'b0, 1'b0, 8'h00);
    issue(OP_PUSH, 1'b1, 1'b1, 8'hFF);
    issue(OP_UNDEF, 1'b0, 1'b1, 8'h5A);
    issue(OP_LINE, 1'b1, 1'b1, 8'h00);
    issue(OP_LINE, 1'b0, 1'b0, 8'h00);
    issue(OP_LINE, 1'b0, 1'b1, 8'h00);
    issue(OP_LINE, 1'b1, 1'b0, 8'h00);
    issue(OP_LINE, 1'b0, 1'b0, 8'h00);
    issue(OP_LINE, 1'b0, 1'b1, 8'h00);
    issue(OP_LINE, 1'b1, 1'b0, 8'h00);

    write_mode(MODE_SEND);
    issue(OP_LINE, 1'b1, 1'b1, 8'h00);
    issue(OP_POP, 1'b1, 1'b1, 8'h00);
    issue(OP_PUSH, 1'b1, 1'b1, 8'h00);
    issue(OP_LINE, 1'b1, 1'b1, 8'h00);
    issue(OP_PUSH, 1'b0, 1'b1, 8'hFF);
    issue(OP_PUSH, 1'b1, 1'b1, 8'h01);
    issue(OP_LINE, 1'b0, 1'b0, 8'h00);
    issue(OP_LINE, 1'b1, 1'b1, 8'h00);
    issue(OP_LINE, 1'b1, 1'b0, 8'h00);
    issue(OP_PUSH, 1'b0, 1'b0, 8'h80);
    issue(OP_LINE, 1'b0, 1'b1, 8'h00);

    for (int prof = 0; prof < 3; prof++) begin
      send_idle_pct = (prof == 0) ? 27 : (prof == 1) ? 86 : 0;
      recv_idle_pct = (prof == 0) ? 86 : (prof == 1) ? 27 : 0;
      write_mode(MODE_RECEIVE);
      repeat (150) rx_step();
      write_mode(MODE_SEND);
      repeat (150) tx_step();
      if (prof == 2) begin
        // fill the buffer with nobody answering, then push into the full buffer
        write_mode(MODE_SEND);
        repeat (BUFFER_DEPTH + 3) issue(OP_PUSH, 1'b1, 1'b1, rnd_byte());
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
